FILE: hw/rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg: shared definitions for the wildcard byte pattern search
// Constants, request codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int MAX_PATTERN_DEFAULT = 32;

   localparam int LENGTH_W = 6;
   localparam int INDEX_W  = 5;
   localparam int ADDR_W   = 32;

   localparam logic [7:0] WILDCARD = 8'h2A;

   localparam logic REQ_WRITE_PATTERN = 1'b0;
   localparam logic REQ_SCAN_DATA     = 1'b1;

   typedef struct packed {
      logic pattern_write;
      logic restart;
      logic step;
      logic load_result;
   } wbps_cmd_type;

   typedef struct packed {
      logic hit;
   } wbps_status_type;

endpackage

FILE: hw/rtl/wbps_channels.sv
// ----------------------------------------------------------------------------
// wbps channels: request and response handshake interfaces
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface wbps_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [4:0]  pattern_index;
   logic [7:0]  pattern_byte;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic        last_byte;
   logic [31:0] region_start;

   modport source (
      output valid, req_type, pattern_index, pattern_byte, data_byte,
             first_byte, last_byte, region_start,
      input  ready
   );
   modport sink (
      input  valid, req_type, pattern_index, pattern_byte, data_byte,
             first_byte, last_byte, region_start,
      output ready
   );
endinterface

interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] match_address;

   modport source (
      output valid, found, match_address,
      input  ready
   );
   modport sink (
      input  valid, found, match_address,
      output ready
   );
endinterface

FILE: hw/rtl/wbps_datapath.sv
// ----------------------------------------------------------------------------
// wbps_datapath: pattern store, partial-match vector and address tracking
// Holds the pattern bytes, the length register, the scan position and the
// response payload register.
// ----------------------------------------------------------------------------
module wbps_datapath #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [4:0]               pattern_index,
   input  logic [7:0]               pattern_byte,
   input  logic [7:0]               data_byte,
   input  logic [31:0]              region_start,
   input  logic                     csr_write_enable,
   input  logic [5:0]               csr_write_data,
   input  wbps_pkg::wbps_cmd_type    cmd,
   output wbps_pkg::wbps_status_type status,
   output logic                     found,
   output logic [31:0]              match_address
);
   import wbps_pkg::*;

   logic [7:0]             store_ff [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] pmv_ff, pmv_in, pmv_base, pmv_new, byte_match;
   logic [ADDR_W-1:0]      offset_ff, offset_in, offset_base;
   logic [ADDR_W-1:0]      base_ff, base_in, base_eff;
   logic [LENGTH_W-1:0]    length_ff, length_in, used_len, len_m1;
   logic                   found_ff, found_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   hit;

   // clamp the programmed length to 1..MAX_PATTERN
   always_comb begin
      used_len = length_ff;
      if (length_ff == '0) begin
         used_len = LENGTH_W'(1);
      end else if (32'(length_ff) > MAX_PATTERN) begin
         used_len = LENGTH_W'(MAX_PATTERN);
      end
      len_m1 = used_len - LENGTH_W'(1);
   end

   always_comb begin
      pmv_base    = cmd.restart ? '0 : pmv_ff;
      offset_base = cmd.restart ? '0 : offset_ff;
      base_eff    = cmd.restart ? region_start : base_ff;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         byte_match[k] = (store_ff[k] == WILDCARD) || (store_ff[k] == data_byte);
      end
      pmv_new[0] = byte_match[0];
      for (int k = 1; k < MAX_PATTERN; k++) begin
         pmv_new[k] = pmv_base[k-1] && byte_match[k];
      end
      hit = 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (32'(len_m1) == k) begin
            hit = pmv_new[k];
         end
      end
   end

   assign status.hit = hit;

   always_comb begin
      pmv_in    = cmd.step ? pmv_new : pmv_base;
      offset_in = cmd.step ? offset_base + ADDR_W'(1) : offset_base;
      base_in   = base_eff;
      length_in = csr_write_enable ? csr_write_data : length_ff;
      found_in  = found_ff;
      addr_in   = addr_ff;
      if (cmd.load_result) begin
         found_in = hit;
         addr_in  = hit ? base_eff + offset_base - ADDR_W'(len_m1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmv_ff    <= '0;
         offset_ff <= '0;
         base_ff   <= '0;
         length_ff <= LENGTH_W'(1);
      end else begin
         pmv_ff    <= pmv_in;
         offset_ff <= offset_in;
         base_ff   <= base_in;
         length_ff <= length_in;
      end
   end

   // pattern bytes and response payload hold no reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (cmd.pattern_write && (32'(pattern_index) == k)) begin
            store_ff[k] <= pattern_byte;
         end
      end
      found_ff <= found_in;
      addr_ff  <= addr_in;
   end

   assign found         = found_ff;
   assign match_address = addr_ff;

   a_restart_offset : assert property (@(posedge clock) disable iff (reset)
      cmd.restart && cmd.step |=> offset_ff == ADDR_W'(1))
      else $error("offset not restarted on first byte");

endmodule

FILE: hw/rtl/wbps_controller.sv
// ----------------------------------------------------------------------------
// wbps_controller: search control and handshake sequencing
// Tracks whether the current region is still being searched, issues datapath
// commands and owns the response valid flag.
// ----------------------------------------------------------------------------
module wbps_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_type,
   input  logic                      first_byte,
   input  logic                      last_byte,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output wbps_pkg::wbps_cmd_type     cmd,
   input  wbps_pkg::wbps_status_type  status
);
   import wbps_pkg::*;

   typedef enum logic [1:0] {
      ST_SEARCH = 2'b01,
      ST_DONE   = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, scan_acc, done_eff;

   // a waiting response blocks the next request unless it drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign scan_acc  = accept && (req_type == REQ_SCAN_DATA);
   assign done_eff  = !first_byte && (state_ff == ST_DONE);

   always_comb begin
      cmd.pattern_write = accept && (req_type == REQ_WRITE_PATTERN);
      cmd.restart       = scan_acc && first_byte;
      cmd.step          = scan_acc && !done_eff;
      cmd.load_result   = cmd.step && (status.hit || last_byte);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SEARCH: begin
            if (cmd.load_result) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (cmd.restart && !cmd.load_result) begin
               state_in = ST_SEARCH;
            end
         end
         default: begin
            state_in = ST_SEARCH;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SEARCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_result_ends_search : assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |=> state_ff == ST_DONE)
      else $error("search not closed after a response");

   a_done_is_silent : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && scan_acc && !first_byte |-> !cmd.load_result)
      else $error("response given after the search ended");

   a_response_from_scan : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(scan_acc))
      else $error("response raised without a scan request");

endmodule

FILE: hw/rtl/wildcard_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search: first-match scan for a wildcard byte pattern
// Loads a pattern byte by byte and reports the address of the earliest match
// of that pattern in a streamed byte region, or not-found at the region's end.
// ----------------------------------------------------------------------------
// The block takes one request (pattern write or data byte) per clock while
// no response is waiting. All pattern positions are held in flip-flops
// and compared against the incoming byte in parallel, with the partial-match
// vector shifting on each data byte of an open search. The response sits in
// an output register; while it waits unaccepted, a new request is taken only
// in the cycle that the response drains. Pattern writes need no response;
// data bytes give at most one (found, or not-found on last byte) per region.
module wildcard_byte_pattern_search #(
   parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   wbps_req_if.sink    req_channel,
   wbps_rsp_if.source  rsp_channel,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data
);
   import wbps_pkg::*;

   wbps_cmd_type    cmd;
   wbps_status_type status;

   wbps_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_channel.valid),
      .req_type   (req_channel.req_type),
      .first_byte (req_channel.first_byte),
      .last_byte  (req_channel.last_byte),
      .req_ready  (req_channel.ready),
      .rsp_valid  (rsp_channel.valid),
      .rsp_ready  (rsp_channel.ready),
      .cmd        (cmd),
      .status     (status)
   );

   wbps_datapath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .pattern_index    (req_channel.pattern_index),
      .pattern_byte     (req_channel.pattern_byte),
      .data_byte        (req_channel.data_byte),
      .region_start     (req_channel.region_start),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .found            (rsp_channel.found),
      .match_address    (rsp_channel.match_address)
   );

endmodule
